FILE: design/lfu_cache_table_core_defines.svh
// Assertion macros for the LFU cache table
`ifndef LFU_CACHE_TABLE_CORE_DEFINES_SVH
`define LFU_CACHE_TABLE_CORE_DEFINES_SVH
// implication assertion, reset-qualified
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication assertion, reset-qualified
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;
    localparam int Capacity  = 16;
    localparam int IdxBits   = $clog2(Capacity);
    localparam int CountBits = 16;
    localparam int CapBits   = 5;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef logic [IdxBits-1:0]   idx_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [IdxBits:0]     cnt_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] lookup_key;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, clear scan state
        logic scan;     // examine entry scan_idx
        logic commit;   // apply the update, build the result
        logic flush;    // invalidate every entry
        idx_t scan_idx;
    } dp_cmd_t;
endpackage

FILE: design/lfu_datapath.sv
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry storage, scan registers for match/free/victim, and the update step.
// ----------------------------------------------------------------------------
module lfu_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  lfu_pkg::dp_cmd_t   cmd,
    input  lfu_pkg::req_t      req,
    input  lfu_pkg::cnt_t      cap,
    output lfu_pkg::rsp_t      rsp
);
    localparam int N = lfu_pkg::Capacity;

    logic [N-1:0]         valid_reg;
    logic [31:0]          key_reg   [N];
    logic [31:0]          value_reg [N];
    lfu_pkg::count_t      count_reg [N];
    lfu_pkg::idx_t        age_reg   [N];

    lfu_pkg::req_t        req_reg;
    logic                 hit_reg, free_reg, vic_reg;
    lfu_pkg::idx_t        hidx_reg, fidx_reg, vidx_reg;
    lfu_pkg::cnt_t        used_reg;

    logic                 in_range;
    lfu_pkg::idx_t        si;
    lfu_pkg::idx_t        tgt;
    logic                 need_ev;
    logic                 do_ins;

    assign si       = cmd.scan_idx;
    assign in_range = ({1'b0, si} < cap);

    // pick the slot touched or written at commit
    always_comb
    begin
        need_ev = !hit_reg && (used_reg >= cap || !free_reg);
        do_ins  = !hit_reg && req_reg.operation == lfu_pkg::OP_PUT && cap != '0;
        if (hit_reg)
            tgt = hidx_reg;
        else if (need_ev)
            tgt = vidx_reg;
        else
            tgt = fidx_reg;
    end

    // scan state: one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            vic_reg  <= 1'b0;
            used_reg <= '0;
            hidx_reg <= '0;
            fidx_reg <= '0;
            vidx_reg <= '0;
        end
        else if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            vic_reg  <= 1'b0;
            used_reg <= '0;
        end
        else if (cmd.scan && in_range)
        begin
            if (valid_reg[si])
            begin
                used_reg <= used_reg + 1'b1;
                if (!hit_reg && key_reg[si] == req_reg.lookup_key)
                begin
                    hit_reg  <= 1'b1;
                    hidx_reg <= si;
                end
                if (!vic_reg || count_reg[si] < count_reg[vidx_reg] ||
                    (count_reg[si] == count_reg[vidx_reg] &&
                     age_reg[si] > age_reg[vidx_reg]))
                begin
                    vic_reg  <= 1'b1;
                    vidx_reg <= si;
                end
            end
            else if (!free_reg)
            begin
                free_reg <= 1'b1;
                fidx_reg <= si;
            end
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.flush)
            valid_reg <= '0;
        else if (cmd.commit && do_ins)
            valid_reg[tgt] <= 1'b1;
    end

    // apply the update: ages of all entries, then the target entry
    always_ff @(posedge clk)
    begin
        if (cmd.commit && cap != '0)
        begin
            for (int j = 0; j < N; j++)
            begin
                if (valid_reg[j] && lfu_pkg::idx_t'(j) != tgt)
                begin
                    if (hit_reg)
                    begin
                        if (age_reg[j] < age_reg[tgt])
                            age_reg[j] <= age_reg[j] + 1'b1;
                    end
                    else if (req_reg.operation == lfu_pkg::OP_PUT)
                    begin
                        // evicted entry drops out; older ones close the gap
                        if (!(need_ev && age_reg[j] > age_reg[tgt]))
                            age_reg[j] <= age_reg[j] + 1'b1;
                    end
                end
            end
            if (hit_reg)
            begin
                age_reg[tgt] <= '0;
                if (count_reg[tgt] != '1)
                    count_reg[tgt] <= count_reg[tgt] + 1'b1;
                if (req_reg.operation == lfu_pkg::OP_PUT)
                    value_reg[tgt] <= req_reg.write_value;
            end
            else if (do_ins)
            begin
                age_reg[tgt]   <= '0;
                count_reg[tgt] <= lfu_pkg::count_t'(1);
                key_reg[tgt]   <= req_reg.lookup_key;
                value_reg[tgt] <= req_reg.write_value;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp.hit         <= hit_reg;
            rsp.read_value  <= (hit_reg && req_reg.operation == lfu_pkg::OP_GET)
                               ? value_reg[hidx_reg] : 32'd0;
            rsp.evicted     <= do_ins && need_ev;
            rsp.evicted_key <= (do_ins && need_ev) ? key_reg[vidx_reg] : 32'd0;
        end
    end
endmodule

FILE: design/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: load, scan every slot, commit, report.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cfg_we,
    output logic             busy,
    output logic             done,
    output lfu_pkg::dp_cmd_t cmd
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    lfu_pkg::idx_t idx_reg, idx_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == lfu_pkg::idx_t'(lfu_pkg::Capacity - 1))
                    state_next = ST_COMMIT;
            end
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = (state_reg == ST_DONE);
    assign cmd.load     = (state_reg == ST_IDLE) && start;
    assign cmd.scan     = (state_reg == ST_SCAN);
    assign cmd.commit   = (state_reg == ST_COMMIT);
    assign cmd.flush    = cfg_we;
    assign cmd.scan_idx = idx_reg;
endmodule

FILE: design/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// LFU key/value table with LRU tie-break, one operation at a time.
//
//   channel  signals                      handshake
//   request  start, busy, req             taken when start & !busy
//   result   done, rsp                    one-cycle strobe, no stall
//   config   cfg_we, cfg_data             taken when cfg_we
//
// Each item runs through a load, a scan of every slot in turn through the
// shared compare unit, commit, then the result strobe. busy stays high
// from acceptance through the strobe. Reset empties the table and sets the
// capacity to 16; a capacity write also empties it.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_core_defines.svh"
module lfu_cache_table_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  lfu_pkg::req_t                 req,
    output logic                          busy,
    output logic                          done,
    output lfu_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [lfu_pkg::CapBits-1:0]   cfg_data
);
    logic [lfu_pkg::CapBits-1:0] cap_reg;
    lfu_pkg::cnt_t               cap_eff;
    lfu_pkg::dp_cmd_t            cmd;

    // hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lfu_pkg::CapBits'(lfu_pkg::Capacity);
        else if (cfg_we)
            cap_reg <= cfg_data;
    end

    // clamp to the physical size
    assign cap_eff = (cap_reg > lfu_pkg::CapBits'(lfu_pkg::Capacity))
                     ? lfu_pkg::cnt_t'(lfu_pkg::Capacity)
                     : lfu_pkg::cnt_t'(cap_reg);

    lfu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_we (cfg_we),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    lfu_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .cap   (cap_eff),
        .rsp   (rsp)
    );

    `LFU_ASSERT_IMP(a_done_busy, done, busy, "done without busy")
    `LFU_ASSERT_NEXT(a_done_idle, done, !busy, "busy after done")
    `LFU_ASSERT_IMP(a_evict_miss, done && rsp.evicted, !rsp.hit, "evict on hit")
endmodule
